@@ hw/rtl/int_constant_lexer_evaluator_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef INT_CONSTANT_LEXER_EVALUATOR_UNIT_ASSERT_SVH
`define INT_CONSTANT_LEXER_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ICLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ICLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Delayed implication.
`define ICLE_ASSERT_DLY2(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/icle_pkg.sv @@
`timescale 1ns / 1ps
package icle_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 16;

   // characters
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_ONE    = 8'd49;
   localparam logic [7:0] CH_SEVEN  = 8'd55;
   localparam logic [7:0] CH_EIGHT  = 8'd56;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_UP_A   = 8'd65;
   localparam logic [7:0] CH_UP_F   = 8'd70;
   localparam logic [7:0] CH_LO_A   = 8'd97;
   localparam logic [7:0] CH_LO_F   = 8'd102;
   localparam logic [7:0] CH_LO_X   = 8'd120;
   localparam logic [7:0] CH_UP_X   = 8'd88;
   localparam logic [7:0] CH_PLUS   = 8'd43;
   localparam logic [7:0] CH_MINUS  = 8'd45;
   localparam logic [7:0] CH_STAR   = 8'd42;

   // lexer states
   localparam logic [2:0] LX_START = 3'd0;
   localparam logic [2:0] LX_ZERO  = 3'd1;
   localparam logic [2:0] LX_DEC   = 3'd2;
   localparam logic [2:0] LX_HEXP  = 3'd3;
   localparam logic [2:0] LX_HEX   = 3'd4;
   localparam logic [2:0] LX_OCT   = 3'd5;
   localparam logic [2:0] LX_ERR   = 3'd6;
   localparam logic [2:0] LX_SIGN  = 3'd7;

   // character classes
   localparam logic [2:0] CC_ZERO  = 3'd0;
   localparam logic [2:0] CC_OCT   = 3'd1;
   localparam logic [2:0] CC_DEC   = 3'd2;
   localparam logic [2:0] CC_HEXL  = 3'd3;
   localparam logic [2:0] CC_X     = 3'd4;
   localparam logic [2:0] CC_OTHER = 3'd5;
   localparam logic [2:0] CC_SIGN  = 3'd6;

   // token kinds
   localparam logic [2:0] TK_NONE = 3'd0;
   localparam logic [2:0] TK_DEC  = 3'd1;
   localparam logic [2:0] TK_OCT  = 3'd2;
   localparam logic [2:0] TK_HEX  = 3'd3;
   localparam logic [2:0] TK_ERR  = 3'd4;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      count_type dec;
      count_type oct;
      count_type hex;
      count_type err;
   } counts_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic                          expr_valid;
      logic signed [VALUE_WIDTH-1:0] value;
      count_type                     decimal_tokens;
      count_type                     octal_tokens;
      count_type                     hex_tokens;
      count_type                     error_tokens;
   } rsp_type;

   // lexer/evaluator state just after the final character
   typedef struct packed {
      logic [2:0] state;
      value_type  cn;
      value_type  tp;
      logic       neg;
      value_type  sum;
      value_type  pend;
      logic       pend_neg;
      counts_type counts;
   } fin_type;

   // expression closed, final multiply and add outstanding
   typedef struct packed {
      logic       expr_valid;
      value_type  sum;
      value_type  tp;
      value_type  cn;
      logic       neg;
      counts_type counts;
   } close_type;

   function automatic logic [2:0] char_class(input logic [7:0] c);
      logic [2:0] cc;
      cc = CC_OTHER;
      if (c == CH_ZERO) cc = CC_ZERO;
      else if (c >= CH_ONE && c <= CH_SEVEN) cc = CC_OCT;
      else if (c >= CH_EIGHT && c <= CH_NINE) cc = CC_DEC;
      else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) cc = CC_HEXL;
      else if (c == CH_LO_X || c == CH_UP_X) cc = CC_X;
      else if (c == CH_PLUS || c == CH_MINUS) cc = CC_SIGN;
      return cc;
   endfunction

   function automatic logic [2:0] dfa_next(input logic [2:0] s, input logic [2:0] cc);
      logic [2:0] n;
      logic       digit;
      digit = (cc == CC_ZERO) || (cc == CC_OCT) || (cc == CC_DEC);
      n = LX_ERR;
      case (s)
         LX_START: begin
            if (cc == CC_ZERO) n = LX_ZERO;
            else if (cc == CC_OCT || cc == CC_DEC) n = LX_DEC;
            else if (cc == CC_SIGN) n = LX_SIGN;
         end
         LX_ZERO: begin
            if (cc == CC_ZERO || cc == CC_OCT) n = LX_OCT;
            else if (cc == CC_X) n = LX_HEXP;
         end
         LX_DEC, LX_SIGN: begin
            if (digit) n = LX_DEC;
         end
         LX_HEXP, LX_HEX: begin
            if (digit || cc == CC_HEXL) n = LX_HEX;
         end
         LX_OCT: begin
            if (cc == CC_ZERO || cc == CC_OCT) n = LX_OCT;
         end
         default: n = LX_ERR;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] token_kind(input logic [2:0] s);
      logic [2:0] k;
      case (s)
         LX_ZERO, LX_OCT: k = TK_OCT;
         LX_DEC:          k = TK_DEC;
         LX_HEXP, LX_HEX: k = TK_HEX;
         LX_ERR:          k = TK_ERR;
         default:         k = TK_NONE;
      endcase
      return k;
   endfunction

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   function automatic counts_type count_token(input counts_type c, input logic [2:0] s);
      counts_type r;
      r = c;
      case (token_kind(s))
         TK_DEC:  r.dec = sat_inc(c.dec);
         TK_OCT:  r.oct = sat_inc(c.oct);
         TK_HEX:  r.hex = sat_inc(c.hex);
         TK_ERR:  r.err = sat_inc(c.err);
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/icle_core.sv @@
`timescale 1ns / 1ps
module icle_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  icle_pkg::req_type req,
   output icle_pkg::fin_type fin
);
   import icle_pkg::*;

   logic [2:0] state_ff;
   value_type  cn_ff;
   value_type  tp_ff;
   logic       neg_ff;
   value_type  sum_ff;
   value_type  pend_ff;
   logic       pend_neg_ff;
   counts_type counts_ff;

   fin_type    post_in;
   logic       is_mul;
   logic       is_add;
   logic       is_digit;
   logic [7:0] digit;
   value_type  product;
   logic       clear;

   assign is_mul   = (req.char_code == CH_STAR);
   assign is_add   = (req.char_code == CH_PLUS) || (req.char_code == CH_MINUS);
   assign is_digit = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);
   assign digit    = req.char_code - CH_ZERO;
   assign product  = tp_ff * cn_ff;

   // the term closed by '+'/'-' is parked in pend and folded into the sum a request later
   always_comb begin
      post_in.state    = dfa_next(state_ff, char_class(req.char_code));
      post_in.cn       = cn_ff;
      post_in.tp       = tp_ff;
      post_in.neg      = neg_ff;
      post_in.sum      = pend_neg_ff ? (sum_ff - pend_ff) : (sum_ff + pend_ff);
      post_in.pend     = '0;
      post_in.pend_neg = 1'b0;
      post_in.counts   = counts_ff;
      if (is_mul || is_add) begin
         post_in.state  = LX_START;
         post_in.cn     = '0;
         post_in.counts = count_token(counts_ff, state_ff);
      end
      if (is_mul) begin
         post_in.tp = product;
      end else if (is_add) begin
         post_in.tp       = value_type'(1);
         post_in.pend     = product;
         post_in.pend_neg = neg_ff;
         post_in.neg      = (req.char_code == CH_MINUS);
      end else if (is_digit) begin
         post_in.cn = (cn_ff << 3) + (cn_ff << 1) + value_type'(digit[3:0]);
      end
   end

   assign fin   = post_in;
   assign clear = reset || (accept && req.last_char);

   always_ff @(posedge clock) begin
      if (clear) begin
         state_ff    <= LX_START;
         cn_ff       <= '0;
         tp_ff       <= value_type'(1);
         neg_ff      <= 1'b0;
         sum_ff      <= '0;
         pend_ff     <= '0;
         pend_neg_ff <= 1'b0;
         counts_ff   <= '0;
      end else if (accept) begin
         state_ff    <= post_in.state;
         cn_ff       <= post_in.cn;
         tp_ff       <= post_in.tp;
         neg_ff      <= post_in.neg;
         sum_ff      <= post_in.sum;
         pend_ff     <= post_in.pend;
         pend_neg_ff <= post_in.pend_neg;
         counts_ff   <= post_in.counts;
      end
   end

endmodule

@@ hw/rtl/icle_close.sv @@
`timescale 1ns / 1ps
module icle_close (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  icle_pkg::fin_type   fin,
   input  logic                down_ready,
   output logic                ready,
   output logic                valid,
   output icle_pkg::close_type cls
);
   import icle_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   close_type cls_ff;
   close_type cls_in;

   // the final term's multiply is left to the next stage
   always_comb begin
      cls_in.counts     = count_token(fin.counts, fin.state);
      cls_in.expr_valid = (cls_in.counts.oct == '0) && (cls_in.counts.hex == '0)
                          && (cls_in.counts.err == '0);
      cls_in.sum        = fin.pend_neg ? (fin.sum - fin.pend) : (fin.sum + fin.pend);
      cls_in.tp         = fin.tp;
      cls_in.cn         = fin.cn;
      cls_in.neg        = fin.neg;
   end

   assign ready    = !valid_ff || down_ready;
   assign valid_in = ready ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cls_ff <= cls_in;
      end
   end

   assign valid = valid_ff;
   assign cls   = cls_ff;

endmodule

@@ hw/rtl/icle_result.sv @@
`timescale 1ns / 1ps
module icle_result (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  icle_pkg::close_type cls,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output icle_pkg::rsp_type   rsp_payload
);
   import icle_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   value_type prod;
   value_type total;

   assign prod  = cls.tp * cls.cn;
   assign total = cls.neg ? (cls.sum - prod) : (cls.sum + prod);

   always_comb begin
      rsp_in.expr_valid     = cls.expr_valid;
      rsp_in.value          = cls.expr_valid ? $signed(total) : '0;
      rsp_in.decimal_tokens = cls.counts.dec;
      rsp_in.octal_tokens   = cls.counts.oct;
      rsp_in.hex_tokens     = cls.counts.hex;
      rsp_in.error_tokens   = cls.counts.err;
   end

   assign ready    = !valid_ff || rsp_ready;
   assign valid_in = ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/int_constant_lexer_evaluator_unit.sv @@
`timescale 1ns / 1ps
// Integer-constant lexer and expression evaluator.
// req_ channel: one character per request (char_code) with last_char marking
// the end of the expression; '+', '-' and '*' split tokens, '*' binds tighter.
// rsp_ channel: one response per expression, sent for the request carrying
// last_char: token counts, expr_valid and the wrapped 32-bit value (zero when
// expr_valid is low). Other requests produce no response.
// Throughput: one request per cycle while req_ready is high; expressions may
// follow back to back. The response passes the close, then the result stage.
// Per character: DFA step, digit accumulate and one 32x32 multiply of the
// registered term; the sum of closed terms is updated a request later; of the
// two result stages, close adds the pending term and result the final term.
// Reset (synchronous, active high) empties both result stages and returns the
// lexer to its start state; the end of each expression also resets the lexer.
// When rsp_ready is low the result stages fill; req_ready drops only once both
// hold a response, then the block waits with all state intact.
module int_constant_lexer_evaluator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  icle_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output icle_pkg::rsp_type rsp_payload
);
   import icle_pkg::*;

   logic      accept;
   logic      load;
   fin_type   fin;
   close_type cls;
   logic      cls_valid;
   logic      result_ready;

   assign accept = req_valid && req_ready;
   assign load   = accept && req_payload.last_char;

   icle_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .fin    (fin)
   );

   icle_close u_close (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .fin        (fin),
      .down_ready (result_ready),
      .ready      (req_ready),
      .valid      (cls_valid),
      .cls        (cls)
   );

   icle_result u_result (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cls_valid),
      .cls         (cls),
      .ready       (result_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ hw/rtl/icle_checker.sv @@
`timescale 1ns / 1ps
`include "int_constant_lexer_evaluator_unit_assert.svh"
module icle_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input icle_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input icle_pkg::rsp_type rsp_payload
);
   import icle_pkg::*;

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       last_taken;
   logic       rsp_taken;

   assign last_taken = req_valid && req_ready && req_payload.last_char;
   assign rsp_taken  = rsp_valid && rsp_ready;

   // expressions closed but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (last_taken && !rsp_taken) pending_in = pending_ff + 2'd1;
      else if (!last_taken && rsp_taken) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ICLE_ASSERT_IMP(a_no_spurious_rsp, clock, reset, rsp_valid, pending_ff != 2'd0,
      "response without a closed expression")

   `ICLE_ASSERT_DLY2(a_rsp_latency, clock, reset, last_taken && pending_ff == 2'd0,
      rsp_valid, "response late on an empty pipeline")

   `ICLE_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && !rsp_payload.expr_valid,
      rsp_payload.value == '0, "value not cleared on invalid expression")

   `ICLE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "stalled response changed")

endmodule

bind int_constant_lexer_evaluator_unit icle_checker u_icle_checker (.*);
